// File: rtl/rssi_peer_tracking_table_top_macros.svh
// assertion macros for the peer tracking table
// used by rssi_peer_tracking_table_top; expects clk and rst in scope
`ifndef RSSI_PEER_TRACKING_TABLE_TOP_MACROS_SVH
`define RSSI_PEER_TRACKING_TABLE_TOP_MACROS_SVH

// same-cycle implication
`define RPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rssi_pt_pkg.sv
// shared types and constants for the peer tracking table
// no dependencies
package rssi_pt_pkg;

  localparam int DEF_PEER_SLOTS = 16;

  // register indexes on the configuration port
  localparam logic [2:0] REG_OWN_ID       = 3'd0;
  localparam logic [2:0] REG_MAKER_CODE   = 3'd1;
  localparam logic [2:0] REG_STALE_MS     = 3'd2;
  localparam logic [2:0] REG_PURGE_MS     = 3'd3;
  localparam logic [2:0] REG_RSSI_FLOOR   = 3'd4;
  localparam logic [2:0] REG_RSSI_CEILING = 3'd5;
  localparam logic [2:0] REG_ALPHA_Q8     = 3'd6;

  localparam logic [15:0]       RST_MAKER_CODE   = 16'h28EF;
  localparam logic [19:0]       RST_STALE_MS     = 20'd7000;
  localparam logic [19:0]       RST_PURGE_MS     = 20'd30000;
  localparam logic signed [7:0] RST_RSSI_FLOOR   = -8'sd90;
  localparam logic signed [7:0] RST_RSSI_CEILING = -8'sd40;
  localparam logic [8:0]        RST_ALPHA_Q8     = 9'd77;

  localparam logic [8:0] ALPHA_ONE = 9'd256;
  localparam logic [6:0] PCT_FULL  = 7'd100;

  // one table entry as held in the slot memory
  typedef struct packed {
    logic [31:0]       id;
    logic signed [7:0] rssi;
    logic [31:0]       seen;
  } entry_t;

endpackage

// File: rtl/rssi_pt_if.sv
// handshake channels of the peer tracking table: input word and result word
// depends on nothing
interface rssi_pt_in_if;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [31:0]       now_ms;
  logic              payload_ok;
  logic [15:0]       adv_maker;
  logic [31:0]       peer_id;
  logic signed [7:0] peer_rssi;
  logic              target_on;
  logic [31:0]       target_id;

  modport source (output valid, kind, now_ms, payload_ok, adv_maker, peer_id,
                  peer_rssi, target_on, target_id, input ready);
  modport sink (input valid, kind, now_ms, payload_ok, adv_maker, peer_id,
                peer_rssi, target_on, target_id, output ready);
endinterface

interface rssi_pt_out_if;
  logic              valid;
  logic              ready;
  logic              found;
  logic [3:0]        slot;
  logic [31:0]       peer_id_out;
  logic signed [7:0] rssi_out;
  logic [6:0]        percent;
  logic [4:0]        fresh_count;
  logic              target_fresh;
  logic signed [7:0] target_rssi;
  logic [6:0]        target_percent;

  modport source (output valid, found, slot, peer_id_out, rssi_out, percent,
                  fresh_count, target_fresh, target_rssi, target_percent,
                  input ready);
  modport sink (input valid, found, slot, peer_id_out, rssi_out, percent,
                fresh_count, target_fresh, target_rssi, target_percent,
                output ready);
endinterface

// File: rtl/rssi_peer_tracking_table_top.sv
// peer tracking table: slot memory, scan sequencer, smoothing and percent divider
// depends on rssi_pt_pkg, rssi_pt_if.sv and the macros header
//
//   port     dir  kind                 content
//   in_ch    in   valid/ready word     advert report or status query
//   out_ch   out  valid/ready word     one result per input word
//   cfg_*    in   write enable/index   seven configuration registers
//
// a word is taken only in the idle state. an advert scans the slots, one
// memory read per slot, then smooths and writes back; a query does the scan,
// then two seven-step divides for the percent figures (skipped when the window
// is empty). a rejected advert goes straight to the done state.
// the slot memory has no reset; only the used bits are cleared by rst.
// a new word is taken while a result still waits in the output register;
// the next result then waits in the done state until the output register frees.
`include "rssi_peer_tracking_table_top_macros.svh"

module rssi_peer_tracking_table_top #(
  parameter int PEER_SLOTS = rssi_pt_pkg::DEF_PEER_SLOTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  rssi_pt_in_if.sink  in_ch,
  rssi_pt_out_if.source out_ch
);

  localparam int IW = $clog2(PEER_SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(PEER_SLOTS - 1);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_SMOOTH = 6'b000100,
    ST_WRITE  = 6'b001000,
    ST_PCT    = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t state;

  // configuration
  logic [31:0]       own_id;
  logic [15:0]       maker_code;
  logic [19:0]       stale_ms;
  logic [19:0]       purge_ms;
  logic signed [7:0] rssi_floor;
  logic signed [7:0] rssi_ceiling;
  logic [8:0]        alpha_q8;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id       <= '0;
      maker_code   <= rssi_pt_pkg::RST_MAKER_CODE;
      stale_ms     <= rssi_pt_pkg::RST_STALE_MS;
      purge_ms     <= rssi_pt_pkg::RST_PURGE_MS;
      rssi_floor   <= rssi_pt_pkg::RST_RSSI_FLOOR;
      rssi_ceiling <= rssi_pt_pkg::RST_RSSI_CEILING;
      alpha_q8     <= rssi_pt_pkg::RST_ALPHA_Q8;
    end else if (cfg_we) begin
      case (cfg_index)
        rssi_pt_pkg::REG_OWN_ID:       own_id       <= cfg_data;
        rssi_pt_pkg::REG_MAKER_CODE:   maker_code   <= cfg_data[15:0];
        rssi_pt_pkg::REG_STALE_MS:     stale_ms     <= cfg_data[19:0];
        rssi_pt_pkg::REG_PURGE_MS:     purge_ms     <= cfg_data[19:0];
        rssi_pt_pkg::REG_RSSI_FLOOR:   rssi_floor   <= cfg_data[7:0];
        rssi_pt_pkg::REG_RSSI_CEILING: rssi_ceiling <= cfg_data[7:0];
        rssi_pt_pkg::REG_ALPHA_Q8:     alpha_q8     <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // latched input word
  logic              kind;
  logic              reject;
  logic [31:0]       now_ms;
  logic [31:0]       peer_id;
  logic signed [7:0] peer_rssi;
  logic              target_on;
  logic [31:0]       target_id;

  logic in_fire;
  assign in_ch.ready = (state == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // slot memory, registered read
  rssi_pt_pkg::entry_t mem [PEER_SLOTS];
  rssi_pt_pkg::entry_t rd_q;
  rssi_pt_pkg::entry_t wr_entry;
  logic [IW-1:0]       idx;
  logic [IW-1:0]       raddr;
  logic [IW-1:0]       wr_idx;
  logic                mem_we;
  logic [PEER_SLOTS-1:0] used;

  assign raddr  = (state == ST_SCAN) ? IW'(idx + 1'b1) : '0;
  assign mem_we = (state == ST_WRITE);

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_idx] <= wr_entry;
    rd_q <= mem[raddr];
  end

  // scan bookkeeping
  logic              match_hit, free_hit, best_hit, tgt_hit, tgt_fresh;
  logic [IW-1:0]     match_idx, free_idx, min_idx, best_idx;
  logic signed [7:0] match_rssi, best_rssi, tgt_rssi;
  logic [31:0]       min_seen, best_id;
  logic [IW:0]       count;

  logic [31:0] age;
  logic        cur_used, purge_now, keep, fresh;
  assign age       = now_ms - rd_q.seen;
  assign cur_used  = used[idx];
  assign purge_now = kind && cur_used && (age > 32'(purge_ms));
  assign keep      = cur_used && !purge_now;
  assign fresh     = keep && (age <= 32'(stale_ms));

  // smoothing
  logic [8:0]         alpha_c, alpha_inv;
  logic signed [17:0] smooth_sum;
  logic signed [17:0] smooth_div;
  logic signed [7:0]  new_rssi;
  assign alpha_c    = (alpha_q8 > rssi_pt_pkg::ALPHA_ONE) ? rssi_pt_pkg::ALPHA_ONE : alpha_q8;
  assign alpha_inv  = rssi_pt_pkg::ALPHA_ONE - alpha_c;
  // truncate toward zero
  assign smooth_div = (smooth_sum < 0) ? ((smooth_sum + 18'sd255) >>> 8) : (smooth_sum >>> 8);

  always_comb begin
    wr_entry.id   = peer_id;
    wr_entry.rssi = match_hit ? smooth_div[7:0] : peer_rssi;
    wr_entry.seen = now_ms;
  end

  // percent of window, restoring divide one quotient bit a cycle
  logic              pct_sel, pct_load;
  logic [2:0]        step;
  logic [15:0]       rem, den_sh;
  logic [6:0]        quo, best_pct, tgt_pct;
  logic signed [7:0] pct_r, r_cl;
  logic signed [8:0] win, n9;
  logic [15:0]       numer;
  logic              win_empty;
  logic [6:0]        empty_pct;
  logic [15:0]       trial;

  assign pct_r     = pct_sel ? tgt_rssi : best_rssi;
  assign win       = 9'(rssi_ceiling) - 9'(rssi_floor);
  assign win_empty = (win <= 0);
  assign empty_pct = (pct_r >= rssi_ceiling) ? rssi_pt_pkg::PCT_FULL : 7'd0;
  assign r_cl      = (pct_r < rssi_floor) ? rssi_floor :
                     (pct_r > rssi_ceiling) ? rssi_ceiling : pct_r;
  assign n9        = 9'(r_cl) - 9'(rssi_floor);
  assign numer     = 16'(16'(n9[7:0]) * 16'd200) + 16'(win[7:0]);
  assign trial     = rem - den_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      used       <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready && state != ST_DONE) out_ch.valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            kind      <= in_ch.kind;
            now_ms    <= in_ch.now_ms;
            peer_id   <= in_ch.peer_id;
            peer_rssi <= in_ch.peer_rssi;
            target_on <= in_ch.target_on;
            target_id <= in_ch.target_id;
            reject    <= !in_ch.kind && (!in_ch.payload_ok ||
                         in_ch.adv_maker != maker_code || in_ch.peer_id == own_id);
            idx       <= '0;
            match_hit <= 1'b0;
            free_hit  <= 1'b0;
            best_hit  <= 1'b0;
            tgt_hit   <= 1'b0;
            tgt_fresh <= 1'b0;
            count     <= '0;
            if (!in_ch.kind && (!in_ch.payload_ok || in_ch.adv_maker != maker_code ||
                in_ch.peer_id == own_id))
              state <= ST_DONE;
            else
              state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (!kind) begin
            if (cur_used && rd_q.id == peer_id && !match_hit) begin
              match_hit  <= 1'b1;
              match_idx  <= idx;
              match_rssi <= rd_q.rssi;
            end
            if (!cur_used && !free_hit) begin
              free_hit <= 1'b1;
              free_idx <= idx;
            end
            if (idx == '0 || rd_q.seen < min_seen) begin
              min_idx  <= idx;
              min_seen <= rd_q.seen;
            end
          end else begin
            if (purge_now) used[idx] <= 1'b0;
            if (fresh) begin
              count <= count + 1'b1;
              if (!best_hit || rd_q.rssi > best_rssi) begin
                best_hit  <= 1'b1;
                best_idx  <= idx;
                best_id   <= rd_q.id;
                best_rssi <= rd_q.rssi;
              end
            end
            if (keep && rd_q.id == target_id && !tgt_hit) begin
              tgt_hit   <= 1'b1;
              tgt_fresh <= fresh;
              tgt_rssi  <= rd_q.rssi;
            end
          end
          idx <= IW'(idx + 1'b1);
          if (idx == LAST_IDX) begin
            pct_sel  <= 1'b0;
            pct_load <= 1'b1;
            state    <= kind ? ST_PCT : ST_SMOOTH;
          end
        end
        ST_SMOOTH: begin
          wr_idx     <= match_hit ? match_idx : (free_hit ? free_idx : min_idx);
          smooth_sum <= 18'($signed({1'b0, alpha_c}) * peer_rssi) +
                        18'($signed({1'b0, alpha_inv}) * match_rssi);
          state      <= ST_WRITE;
        end
        ST_WRITE: begin
          used[wr_idx] <= 1'b1;
          new_rssi     <= wr_entry.rssi;
          state        <= ST_DONE;
        end
        ST_PCT: begin
          if (pct_load) begin
            // an empty window skips the divide, straight on to the target figure
            pct_load <= win_empty && !pct_sel;
            rem      <= numer;
            den_sh   <= 16'({win[7:0], 1'b0}) << 6;
            quo      <= '0;
            step     <= 3'd6;
            if (win_empty) begin
              if (pct_sel) begin
                tgt_pct <= empty_pct;
                state   <= ST_DONE;
              end else begin
                best_pct <= empty_pct;
                pct_sel  <= 1'b1;
              end
            end
          end else begin
            if (rem >= den_sh) rem <= trial;
            quo    <= {quo[5:0], rem >= den_sh};
            den_sh <= den_sh >> 1;
            step   <= step - 3'd1;
            if (step == 3'd0) begin
              if (pct_sel) begin
                tgt_pct <= {quo[5:0], rem >= den_sh};
                state   <= ST_DONE;
              end else begin
                best_pct <= {quo[5:0], rem >= den_sh};
                pct_sel  <= 1'b1;
                pct_load <= 1'b1;
              end
            end
          end
        end
        ST_DONE: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output word payload
  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_ch.valid || out_ch.ready)) begin
      out_ch.found          <= 1'b0;
      out_ch.slot           <= '0;
      out_ch.peer_id_out    <= '0;
      out_ch.rssi_out       <= '0;
      out_ch.percent        <= '0;
      out_ch.fresh_count    <= '0;
      out_ch.target_fresh   <= 1'b0;
      out_ch.target_rssi    <= '0;
      out_ch.target_percent <= '0;
      if (!kind && !reject) begin
        out_ch.found       <= 1'b1;
        out_ch.slot        <= 4'(wr_idx);
        out_ch.peer_id_out <= peer_id;
        out_ch.rssi_out    <= new_rssi;
      end else if (kind) begin
        out_ch.fresh_count <= 5'(count);
        if (best_hit) begin
          out_ch.found       <= 1'b1;
          out_ch.slot        <= 4'(best_idx);
          out_ch.peer_id_out <= best_id;
          out_ch.rssi_out    <= best_rssi;
          out_ch.percent     <= best_pct;
        end
        if (target_on && tgt_hit && tgt_fresh) begin
          out_ch.target_fresh   <= 1'b1;
          out_ch.target_rssi    <= tgt_rssi;
          out_ch.target_percent <= tgt_pct;
        end
      end
    end
  end

  `RPT_ASSERT_NEXT(a_accept_starts, in_fire, state == ST_SCAN || state == ST_DONE,
                   "word accepted but sequencer idle")
  `RPT_ASSERT_NEXT(a_scan_walks, state == ST_SCAN && idx != LAST_IDX,
                   idx == IW'($past(idx) + 1'b1), "scan index skipped")
  `RPT_ASSERT_NOW(a_pct_range, out_ch.valid,
                  out_ch.percent <= rssi_pt_pkg::PCT_FULL &&
                  out_ch.target_percent <= rssi_pt_pkg::PCT_FULL, "percent above full")
  `RPT_ASSERT_NOW(a_not_found_zero, out_ch.valid && !out_ch.found,
                  out_ch.percent == 7'd0 && out_ch.rssi_out == 8'sd0,
                  "fields set without a peer")

endmodule

// File: sim/rssi_peer_tracking_table_top_tb.sv
// testbench for the peer tracking table: adverts, queries, purge, smoothing and percent
// depends on rssi_pt_pkg, rssi_pt_if.sv and rssi_peer_tracking_table_top
module rssi_peer_tracking_table_top_tb;

  localparam int NSLOT = 16;
  localparam int CYCLE_LIMIT = 900000;

  typedef struct packed {
    logic              kind;
    logic [31:0]       now_ms;
    logic              payload_ok;
    logic [15:0]       adv_maker;
    logic [31:0]       peer_id;
    logic signed [7:0] peer_rssi;
    logic              target_on;
    logic [31:0]       target_id;
  } req_t;

  typedef struct packed {
    logic              found;
    logic [3:0]        slot;
    logic [31:0]       peer_id_out;
    logic signed [7:0] rssi_out;
    logic [6:0]        percent;
    logic [4:0]        fresh_count;
    logic              target_fresh;
    logic signed [7:0] target_rssi;
    logic [6:0]        target_percent;
  } rep_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_index = rssi_pt_pkg::REG_OWN_ID;
  logic [31:0] cfg_data = 0;

  rssi_pt_in_if in_ch();
  rssi_pt_out_if out_ch();

  rssi_peer_tracking_table_top DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.source), .out_ch(out_ch.sink)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor state
  logic [31:0] m_own;
  logic [15:0] m_maker;
  logic [19:0] m_stale, m_purge;
  int m_floor, m_ceil;
  logic [8:0] m_alpha;
  bit m_used[NSLOT];
  logic [31:0] m_id[NSLOT];
  int m_rssi[NSLOT];
  logic [31:0] m_seen[NSLOT];

  rep_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_idle = 0;
  bit recv_hold = 0;

  function automatic logic [6:0] window_pct(int r);
    int d, n;
    d = m_ceil - m_floor;
    if (d <= 0) return (r >= m_ceil) ? rssi_pt_pkg::PCT_FULL : 7'd0;
    if (r < m_floor) r = m_floor;
    if (r > m_ceil) r = m_ceil;
    n = r - m_floor;
    return 7'((200 * n + d) / (2 * d));
  endfunction

  function automatic bit is_fresh(int i, logic [31:0] now);
    logic [31:0] age;
    age = now - m_seen[i];
    return m_used[i] && age <= {12'd0, m_stale};
  endfunction

  function automatic rep_t table_step(req_t q);
    rep_t r;
    int idx, best, t, a, s;
    bit taken;
    logic [31:0] age;
    r = '0;
    idx = -1;
    best = -1;
    t = -1;
    taken = 0;
    if (q.kind == 1'b0) begin
      if (!q.payload_ok || q.adv_maker != m_maker || q.peer_id == m_own) return r;
      for (int i = 0; i < NSLOT; i++)
        if (idx < 0 && m_used[i] && m_id[i] == q.peer_id) idx = i;
      if (idx < 0) begin
        taken = 1;
        for (int i = 0; i < NSLOT; i++) if (idx < 0 && !m_used[i]) idx = i;
        if (idx < 0) begin
          idx = 0;
          for (int i = 1; i < NSLOT; i++) if (m_seen[i] < m_seen[idx]) idx = i;
        end
        m_used[idx] = 1;
        m_id[idx] = q.peer_id;
      end
      if (taken) m_rssi[idx] = q.peer_rssi;
      else begin
        a = (m_alpha > rssi_pt_pkg::ALPHA_ONE) ? 256 : int'(m_alpha);
        s = a * int'(q.peer_rssi) + (256 - a) * m_rssi[idx];
        m_rssi[idx] = s / 256;
      end
      m_seen[idx] = q.now_ms;
      r.found = 1;
      r.slot = 4'(idx);
      r.peer_id_out = q.peer_id;
      r.rssi_out = 8'(m_rssi[idx]);
    end else begin
      for (int i = 0; i < NSLOT; i++) begin
        age = q.now_ms - m_seen[i];
        if (m_used[i] && age > {12'd0, m_purge}) m_used[i] = 0;
      end
      for (int i = 0; i < NSLOT; i++) begin
        if (is_fresh(i, q.now_ms)) begin
          r.fresh_count = r.fresh_count + 5'd1;
          if (best < 0 || m_rssi[i] > m_rssi[best]) best = i;
        end
      end
      if (best >= 0) begin
        r.found = 1;
        r.slot = 4'(best);
        r.peer_id_out = m_id[best];
        r.rssi_out = 8'(m_rssi[best]);
        r.percent = window_pct(m_rssi[best]);
      end
      if (q.target_on) begin
        for (int i = 0; i < NSLOT; i++)
          if (t < 0 && m_used[i] && m_id[i] == q.target_id) t = i;
        if (t >= 0 && is_fresh(t, q.now_ms)) begin
          r.target_fresh = 1;
          r.target_rssi = 8'(m_rssi[t]);
          r.target_percent = window_pct(m_rssi[t]);
        end
      end
    end
    return r;
  endfunction

  task automatic reset_predictor();
    m_own = 0;
    m_maker = rssi_pt_pkg::RST_MAKER_CODE;
    m_stale = rssi_pt_pkg::RST_STALE_MS;
    m_purge = rssi_pt_pkg::RST_PURGE_MS;
    m_floor = rssi_pt_pkg::RST_RSSI_FLOOR;
    m_ceil = rssi_pt_pkg::RST_RSSI_CEILING;
    m_alpha = rssi_pt_pkg::RST_ALPHA_Q8;
    for (int i = 0; i < NSLOT; i++) begin
      m_used[i] = 0;
      m_id[i] = 0;
      m_rssi[i] = 0;
      m_seen[i] = 0;
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL rssi_peer_tracking_table_top");
      $finish;
    end
  end

  // result side: random stall, or a held-off stretch
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 0;
    else out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    rep_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.found, out_ch.slot, out_ch.peer_id_out, out_ch.rssi_out,
              out_ch.percent, out_ch.fresh_count, out_ch.target_fresh,
              out_ch.target_rssi, out_ch.target_percent};
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result word %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.found !== want.found || got.slot !== want.slot ||
            got.peer_id_out !== want.peer_id_out || got.rssi_out !== want.rssi_out ||
            got.percent !== want.percent || got.fresh_count !== want.fresh_count ||
            got.target_fresh !== want.target_fresh ||
            got.target_rssi !== want.target_rssi ||
            got.target_percent !== want.target_percent) begin
          $display("%0t mismatch expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    end
  end

  // valid stays up after the last accepted word until idling or drain drops it
  task automatic send_word(req_t q);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    {in_ch.kind, in_ch.now_ms, in_ch.payload_ok, in_ch.adv_maker, in_ch.peer_id,
     in_ch.peer_rssi, in_ch.target_on, in_ch.target_id} <= q;
    do @(posedge clk); while (!in_ch.ready);
    pending_results = {pending_results, table_step(q)};
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] index, logic [31:0] value);
    cfg_we <= 1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    case (index)
      rssi_pt_pkg::REG_OWN_ID:       m_own = value;
      rssi_pt_pkg::REG_MAKER_CODE:   m_maker = value[15:0];
      rssi_pt_pkg::REG_STALE_MS:     m_stale = value[19:0];
      rssi_pt_pkg::REG_PURGE_MS:     m_purge = value[19:0];
      rssi_pt_pkg::REG_RSSI_FLOOR:   m_floor = $signed(value[7:0]);
      rssi_pt_pkg::REG_RSSI_CEILING: m_ceil = $signed(value[7:0]);
      rssi_pt_pkg::REG_ALPHA_Q8:     m_alpha = value[8:0];
      default: ;
    endcase
  endtask

  function automatic req_t advert(logic [31:0] now, logic [31:0] id, logic signed [7:0] r);
    req_t q;
    q = '0;
    q.now_ms = now;
    q.payload_ok = 1;
    q.adv_maker = m_maker;
    q.peer_id = id;
    q.peer_rssi = r;
    q.target_id = $urandom;
    return q;
  endfunction

  function automatic req_t query(logic [31:0] now, logic ton, logic [31:0] tid);
    req_t q;
    q = '0;
    q.kind = 1;
    q.now_ms = now;
    q.payload_ok = 1'($urandom_range(1));
    q.adv_maker = 16'($urandom);
    q.peer_id = $urandom;
    q.peer_rssi = 8'($urandom);
    q.target_on = ton;
    q.target_id = tid;
    return q;
  endfunction

  task automatic test_directed();
    req_t q;
    send_word(query(0, 1, 32'h1));
    send_word(advert(100, 32'h1, -8'sd128));
    send_word(advert(200, 32'h1, 8'sd127));
    send_word(advert(300, 32'hFFFF_FFFF, -8'sd60));
    q = advert(400, 32'h5, 0);
    q.payload_ok = 0;
    send_word(q);
    q = advert(400, 32'h5, 0);
    q.adv_maker = ~m_maker;
    send_word(q);
    send_word(advert(400, m_own, 0));
    send_word(query(500, 1, 32'hFFFF_FFFF));
    send_word(query(7300, 1, 32'h1));
    for (int i = 0; i < NSLOT + 2; i++) send_word(advert(1000 + i, 32'h100 + i, 8'(-100 + 5 * i)));
    send_word(query(32'hFFFF_FFF0, 1, 32'h105));
    send_word(query(40000, 1, 32'h100));
    drain();
  endtask

  task automatic write_settings(int pick);
    case (pick)
      0: begin
        write_reg(rssi_pt_pkg::REG_OWN_ID, 32'hFFFF_FFFF);
        write_reg(rssi_pt_pkg::REG_MAKER_CODE, 16'hFFFF);
        write_reg(rssi_pt_pkg::REG_STALE_MS, 20'hFFFFF);
        write_reg(rssi_pt_pkg::REG_PURGE_MS, 20'hFFFFF);
        write_reg(rssi_pt_pkg::REG_RSSI_FLOOR, 8'h80);
        write_reg(rssi_pt_pkg::REG_RSSI_CEILING, 8'h7F);
        write_reg(rssi_pt_pkg::REG_ALPHA_Q8, 9'h1FF);
      end
      1: begin
        write_reg(rssi_pt_pkg::REG_OWN_ID, 0);
        write_reg(rssi_pt_pkg::REG_MAKER_CODE, 0);
        write_reg(rssi_pt_pkg::REG_STALE_MS, 0);
        write_reg(rssi_pt_pkg::REG_PURGE_MS, 0);
        write_reg(rssi_pt_pkg::REG_RSSI_FLOOR, 8'd126);
        write_reg(rssi_pt_pkg::REG_RSSI_CEILING, 8'h81);
        write_reg(rssi_pt_pkg::REG_ALPHA_Q8, 0);
      end
      2: begin
        write_reg(rssi_pt_pkg::REG_OWN_ID, 32'h7);
        write_reg(rssi_pt_pkg::REG_MAKER_CODE, 16'h28EF);
        write_reg(rssi_pt_pkg::REG_STALE_MS, 60);
        write_reg(rssi_pt_pkg::REG_PURGE_MS, 150);
        write_reg(rssi_pt_pkg::REG_RSSI_FLOOR, 8'hB0);
        write_reg(rssi_pt_pkg::REG_RSSI_CEILING, 8'hB0);
        write_reg(rssi_pt_pkg::REG_ALPHA_Q8, 256);
      end
      default: begin
        write_reg(rssi_pt_pkg::REG_OWN_ID, $urandom_range(15));
        write_reg(rssi_pt_pkg::REG_MAKER_CODE, $urandom);
        write_reg(rssi_pt_pkg::REG_STALE_MS, $urandom_range(80, 20));
        write_reg(rssi_pt_pkg::REG_PURGE_MS, $urandom_range(300, 50));
        write_reg(rssi_pt_pkg::REG_RSSI_FLOOR, $urandom_range(255));
        write_reg(rssi_pt_pkg::REG_RSSI_CEILING, $urandom_range(255));
        write_reg(rssi_pt_pkg::REG_ALPHA_Q8, $urandom_range(300));
      end
    endcase
    cfg_we <= 0;
  endtask

  // ids from a small pool so adverts hit slots, evict and get purged
  task automatic run_random(int count);
    logic [31:0] clock_ms;
    req_t q;
    clock_ms = $urandom;
    for (int n = 0; n < count; n++) begin
      clock_ms += $urandom_range(12);
      if ($urandom_range(9) < 6) begin
        q = advert(clock_ms, $urandom_range(22), 8'($urandom));
        if ($urandom_range(19) == 0) q.payload_ok = 0;
        if ($urandom_range(19) == 0) q.adv_maker = 16'($urandom);
        if ($urandom_range(29) == 0) q.peer_id = m_own;
        if ($urandom_range(29) == 0) q.peer_id = $urandom;
        if ($urandom_range(39) == 0) q.now_ms = $urandom;
      end else begin
        q = query(clock_ms, 1'($urandom_range(1)), $urandom_range(22));
        if ($urandom_range(39) == 0) q.target_id = $urandom;
      end
      send_word(q);
    end
  endtask

  task automatic test_back_pressure();
    fork
      begin
        recv_hold = 1;
        repeat (300) @(posedge clk);
        recv_hold = 0;
      end
      run_random(20);
    join
    drain();
  endtask

  initial begin
    in_ch.valid = 0;
    {in_ch.kind, in_ch.now_ms, in_ch.payload_ok, in_ch.adv_maker, in_ch.peer_id,
     in_ch.peer_rssi, in_ch.target_on, in_ch.target_id} = '0;
    reset_predictor();
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    for (int p = 0; p < 3; p++) begin
      write_settings(p);
      send_idle = (p == 0) ? 17 : (p == 1) ? 78 : 0;
      recv_idle = (p == 0) ? 78 : (p == 1) ? 17 : 0;
      run_random(60);
      drain();
    end
    send_idle = 17;
    recv_idle = 78;
    write_settings(3);
    run_random(400);
    drain();
    send_idle = 78;
    recv_idle = 17;
    write_settings(3);
    run_random(400);
    drain();
    send_idle = 0;
    recv_idle = 0;
    write_settings(3);
    run_random(320);
    test_back_pressure();
    if (errors == 0) $display("PASS rssi_peer_tracking_table_top");
    else $display("FAIL rssi_peer_tracking_table_top");
    $finish;
  end
endmodule
